### rtl/core/kos_pkg.sv
package kos_pkg;

  // field widths
  localparam int ACT_W  = 2;
  localparam int SLOT_W = 10;
  localparam int WGT_W  = 8;
  localparam int SUM_W  = 18;
  localparam int POS_W  = 10;
  localparam int SIU_W  = 11;

  // default slot count and register reset value
  localparam int SLOTS_DEF = 1024;
  localparam int SIU_RESET = 1024;
  localparam int SIU_ALL   = 2 ** SIU_W - 1;

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [WGT_W-1:0]  weight_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [SIU_W-1:0]  siu_t;

  // action codes
  localparam action_t ACT_REBUILD = 2'd0;
  localparam action_t ACT_SET     = 2'd1;
  localparam action_t ACT_FIND    = 2'd2;

  typedef struct packed {
    action_t action;
    slot_t   slot;
    weight_t weight;
    sum_t    rank;
  } in_item_t;

  typedef struct packed {
    logic found;
    pos_t position;
    sum_t total_weight;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic cfg_load;
    logic sweep_init;
    logic sweep_step;
    logic item_load;
    logic set_leaf;
    logic set_up;
    logic find_start;
    logic find_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    action_t action;
    logic    sweep_last;
    logic    set_ok;
    logic    set_last;
    logic    find_ok;
    logic    find_last;
    logic    out_free;
  } sts_t;

endpackage

### rtl/core/kos_dpath.sv
module kos_dpath #(
  parameter int SLOTS = kos_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kos_pkg::cmd_t      cmd,
  output kos_pkg::sts_t      sts,
  input  kos_pkg::in_item_t  in_data,
  input  kos_pkg::siu_t      cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output kos_pkg::out_item_t out_data
);

  localparam int LVL   = $clog2(SLOTS);
  localparam int AW    = LVL + 1;
  localparam int DEPTH = 2 ** AW;
  localparam int CW    = (LVL + 2 > kos_pkg::SIU_W + 1) ? LVL + 2 : kos_pkg::SIU_W + 1;
  localparam logic [LVL:0] SPAN_FULL = {1'b1, {LVL{1'b0}}};
  localparam logic [AW-1:0] ROOT     = AW'(1);
  localparam logic [AW-1:0] ROOT_L   = AW'(2);
  localparam kos_pkg::siu_t SIU_MAX  = (SLOTS > kos_pkg::SIU_ALL) ?
                                       kos_pkg::siu_t'(kos_pkg::SIU_ALL) :
                                       kos_pkg::siu_t'(SLOTS);
  localparam kos_pkg::siu_t SIU_RST  = (SLOTS < kos_pkg::SIU_RESET) ?
                                       kos_pkg::siu_t'(SLOTS) :
                                       kos_pkg::siu_t'(kos_pkg::SIU_RESET);

  // node sum memory, root at index one
  kos_pkg::sum_t mem [DEPTH];
  kos_pkg::sum_t rdata_r;

  kos_pkg::siu_t     siu_r;
  kos_pkg::sum_t     total_r;
  kos_pkg::in_item_t item_r;
  logic [AW-1:0]     node_r;
  kos_pkg::sum_t     acc_r;
  logic              found_r;
  kos_pkg::pos_t     pos_r;
  logic [LVL:0]      base_r;
  logic [LVL:0]      span_r;
  logic [AW-1:0]     swaddr_r;
  logic              out_valid_r;
  kos_pkg::out_item_t out_data_r;

  logic [LVL-1:0]    slot_ext;
  logic [AW-1:0]     leaf_addr;
  logic [AW-1:0]     parent;
  logic [AW-1:0]     child;
  logic              go_left;
  kos_pkg::sum_t     need_nxt;
  kos_pkg::sum_t     up_sum;
  logic [LVL:0]      base_sum;
  logic [CW-1:0]     siu_c;
  logic [CW-1:0]     base_c;
  logic [CW-1:0]     span_c;
  logic [CW-1:0]     rem_c;
  logic [CW-1:0]     sw_val;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  kos_pkg::sum_t     wdata;
  kos_pkg::siu_t     cfg_clamp;

  // tree walk address and sum logic
  assign slot_ext  = LVL'(item_r.slot);
  assign leaf_addr = {1'b1, slot_ext};
  assign parent    = {1'b0, node_r[AW-1:1]};
  assign up_sum    = acc_r + rdata_r;
  assign go_left   = rdata_r >= acc_r;
  assign need_nxt  = go_left ? acc_r : acc_r - rdata_r;
  assign child     = {node_r[AW-2:0], ~go_left};

  // rebuild value of the node being swept: overlap of its span with slots in use
  assign base_sum = base_r + span_r;
  assign siu_c    = CW'(siu_r);
  assign base_c   = CW'(base_r);
  assign span_c   = CW'(span_r);
  assign rem_c    = (siu_c > base_c) ? siu_c - base_c : '0;
  assign sw_val   = (rem_c > span_c) ? span_c : rem_c;

  // register write clamp
  always_comb begin
    cfg_clamp = cfg_data;
    if (cfg_clamp == '0) begin
      cfg_clamp = kos_pkg::siu_t'(1);
    end
    if (cfg_clamp > SIU_MAX) begin
      cfg_clamp = SIU_MAX;
    end
  end

  // memory port selection
  assign we = cmd.sweep_step | cmd.set_leaf | cmd.set_up;

  always_comb begin
    if (cmd.sweep_step) begin
      waddr = swaddr_r;
      wdata = kos_pkg::sum_t'(sw_val);
    end else if (cmd.set_leaf) begin
      waddr = leaf_addr;
      wdata = kos_pkg::sum_t'(item_r.weight);
    end else begin
      waddr = parent;
      wdata = up_sum;
    end
  end

  always_comb begin
    if (cmd.set_leaf) begin
      raddr = leaf_addr ^ ROOT;
    end else if (cmd.set_up) begin
      raddr = parent ^ ROOT;
    end else if (cmd.find_start) begin
      raddr = ROOT_L;
    end else begin
      raddr = {child[AW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // slot count register and sweep counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      siu_r    <= SIU_RST;
      base_r   <= '0;
      span_r   <= SPAN_FULL;
      swaddr_r <= ROOT;
    end else begin
      if (cmd.cfg_load) begin
        siu_r <= cfg_clamp;
      end
      if (cmd.sweep_init) begin
        base_r   <= '0;
        span_r   <= SPAN_FULL;
        swaddr_r <= ROOT;
      end else if (cmd.sweep_step) begin
        swaddr_r <= swaddr_r + ROOT;
        if (base_sum == SPAN_FULL) begin
          base_r <= '0;
          span_r <= span_r >> 1;
        end else begin
          base_r <= base_sum;
        end
      end
    end
  end

  // item, walk state and result
  always_ff @(posedge clk) begin
    if (cmd.sweep_step && sts.sweep_last) begin
      total_r <= kos_pkg::sum_t'(siu_r);
    end
    if (cmd.item_load) begin
      item_r  <= in_data;
      found_r <= 1'b0;
      pos_r   <= '0;
    end
    if (cmd.set_leaf) begin
      node_r <= leaf_addr;
      acc_r  <= kos_pkg::sum_t'(item_r.weight);
    end
    if (cmd.set_up) begin
      node_r <= parent;
      acc_r  <= up_sum;
      if (sts.set_last) begin
        total_r <= up_sum;
      end
    end
    if (cmd.find_start) begin
      node_r <= ROOT;
      acc_r  <= item_r.rank;
    end
    if (cmd.find_step) begin
      node_r <= child;
      acc_r  <= need_nxt;
      if (sts.find_last) begin
        found_r <= 1'b1;
        pos_r   <= kos_pkg::pos_t'(child[LVL-1:0]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.found        <= found_r;
      out_data_r.position     <= pos_r;
      out_data_r.total_weight <= total_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status back to the controller
  assign sts.action     = item_r.action;
  assign sts.sweep_last = (span_r == (LVL + 1)'(1)) && (base_sum == SPAN_FULL);
  assign sts.set_ok     = {1'b0, item_r.slot} < siu_r;
  assign sts.set_last   = parent == ROOT;
  assign sts.find_ok    = total_r >= item_r.rank;
  assign sts.find_last  = child[AW-1];
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

### rtl/core/kos_ctrl.sv
module kos_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  output kos_pkg::cmd_t cmd,
  input  kos_pkg::sts_t sts
);

  localparam logic [2:0] ST_SWEEP      = 3'd0;
  localparam logic [2:0] ST_IDLE       = 3'd1;
  localparam logic [2:0] ST_DISPATCH   = 3'd2;
  localparam logic [2:0] ST_SET_LEAF   = 3'd3;
  localparam logic [2:0] ST_SET_UP     = 3'd4;
  localparam logic [2:0] ST_FIND_START = 3'd5;
  localparam logic [2:0] ST_FIND_STEP  = 3'd6;
  localparam logic [2:0] ST_DONE       = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       item_r;
  logic       item_nxt;

  assign cfg_ready = state_r == ST_IDLE;
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    cmd       = '0;
    case (state_r)
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          item_nxt  = 1'b0;
          state_nxt = item_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_load   = 1'b1;
          cmd.sweep_init = 1'b1;
          item_nxt       = 1'b0;
          state_nxt      = ST_SWEEP;
        end else if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.action)
          kos_pkg::ACT_REBUILD: begin
            cmd.sweep_init = 1'b1;
            item_nxt       = 1'b1;
            state_nxt      = ST_SWEEP;
          end
          kos_pkg::ACT_SET: begin
            state_nxt = sts.set_ok ? ST_SET_LEAF : ST_DONE;
          end
          kos_pkg::ACT_FIND: begin
            state_nxt = sts.find_ok ? ST_FIND_START : ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_SET_LEAF: begin
        cmd.set_leaf = 1'b1;
        state_nxt    = ST_SET_UP;
      end
      ST_SET_UP: begin
        cmd.set_up = 1'b1;
        if (sts.set_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_FIND_START: begin
        cmd.find_start = 1'b1;
        state_nxt      = ST_FIND_STEP;
      end
      ST_FIND_STEP: begin
        cmd.find_step = 1'b1;
        if (sts.find_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      item_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      item_r  <= item_nxt;
    end
  end

endmodule

### rtl/core/kth_occupied_slot_tree.sv
// find and set: one memory access per tree level; the result is held in the output
//   register until taken, and the next request is accepted only after it is loaded
// rebuild and register write: a sweep over the node memory from the root to the leaves,
//   one node written per cycle; the rebuild result follows once the sweep ends
// reset: synchronous active-low rst_n, then the same sweep before the first request
//   is accepted; register writes wait for it too
module kth_occupied_slot_tree #(
  parameter int SLOTS = kos_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kos_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output kos_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  kos_pkg::siu_t      cfg_data
);

  kos_pkg::cmd_t cmd;
  kos_pkg::sts_t sts;

  // sequencer
  kos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // node memory and walk datapath
  kos_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/core/kos_checker.sv
module kos_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input kos_pkg::out_item_t out_data,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request at a time
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !cfg_ready)
    else $error("request accepted while busy");

  // a register write starts a rebuild sweep
  a_cfg_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready ##1 !in_ready)
    else $error("request taken during rebuild");

  // not found reports slot zero
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.position == '0)
    else $error("position set without a find hit");

endmodule

bind kth_occupied_slot_tree kos_checker u_kos_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

### dv/kos_answer_checker.sv
`timescale 1ns / 1ps

module kos_answer_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  kos_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  kos_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  kos_pkg::siu_t      cfg_data,
  output int                 fail_count,
  output int                 answers_owed,
  output int                 answers_seen,
  output int                 ranks_located,
  output int                 weight_total_now
);

  // own copy of the block state: one weight per slot plus the running total
  kos_pkg::weight_t   slot_weight [kos_pkg::SLOTS_DEF];
  int unsigned        slots_live;
  int unsigned        weight_total;
  kos_pkg::out_item_t answers_due [$];

  task automatic report_mismatch(string msg);
    fail_count++;
    $display("[%0t] mismatch at result %0d: %s", $realtime, answers_seen, msg);
  endtask

  // every slot in use back to weight one, the rest to zero
  function automatic void refill_slots();
    for (int i = 0; i < kos_pkg::SLOTS_DEF; i++) begin
      slot_weight[i] = (i < slots_live) ? kos_pkg::weight_t'(1) : kos_pkg::weight_t'(0);
    end
    weight_total = slots_live;
  endfunction

  // apply one request to the state and work out its answer
  function automatic kos_pkg::out_item_t predict_answer(kos_pkg::in_item_t req);
    kos_pkg::out_item_t ans;
    int unsigned        acc;
    bit                 located;
    ans = '0;
    acc = 0;
    located = 1'b0;
    case (req.action)
      kos_pkg::ACT_REBUILD: begin
        refill_slots();
      end
      kos_pkg::ACT_SET: begin
        if (req.slot < slots_live) begin
          weight_total = weight_total - slot_weight[req.slot] + req.weight;
          slot_weight[req.slot] = req.weight;
        end
      end
      kos_pkg::ACT_FIND: begin
        // lowest slot whose running prefix reaches the rank
        if (weight_total >= req.rank) begin
          ans.found = 1'b1;
          for (int i = 0; i < kos_pkg::SLOTS_DEF; i++) begin
            acc += slot_weight[i];
            if (!located && acc >= req.rank) begin
              located = 1'b1;
              ans.position = kos_pkg::pos_t'(i);
            end
          end
        end
      end
      default: begin
      end
    endcase
    ans.total_weight = kos_pkg::sum_t'(weight_total);
    return ans;
  endfunction

  // sample all three channels at the rising edge
  always @(posedge clk) begin
    kos_pkg::out_item_t want;
    if (!rst_n) begin
      slots_live = kos_pkg::SIU_RESET;
      refill_slots();
      answers_due.delete();
    end else begin
      // result side first: it always belongs to an older request
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", out_data));
        end else begin
          want = answers_due.pop_front();
          if (out_data.found !== want.found) begin
            report_mismatch($sformatf("found got %0d expected %0d",
                                      out_data.found, want.found));
          end
          if (out_data.position !== want.position) begin
            report_mismatch($sformatf("position got %0d expected %0d",
                                      out_data.position, want.position));
          end
          if (out_data.total_weight !== want.total_weight) begin
            report_mismatch($sformatf("total_weight got %0d expected %0d",
                                      out_data.total_weight, want.total_weight));
          end
          if (want.found) begin
            ranks_located++;
          end
        end
        answers_seen++;
      end
      // slot count write: clamp into range, then rebuild
      if (cfg_valid && cfg_ready) begin
        if (cfg_data == '0) begin
          slots_live = 1;
        end else if (cfg_data > kos_pkg::SLOTS_DEF) begin
          slots_live = kos_pkg::SLOTS_DEF;
        end else begin
          slots_live = cfg_data;
        end
        refill_slots();
      end
      if (in_valid && in_ready) begin
        answers_due.push_back(predict_answer(in_data));
      end
    end
    answers_owed = answers_due.size();
    weight_total_now = weight_total;
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

  // action code the block must treat as a no-op
  localparam kos_pkg::action_t ACT_NONE = 2'd3;
  localparam int RANDOM_PER_PHASE = 233;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  kos_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  kos_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  kos_pkg::siu_t      cfg_data = '0;

  int fail_count;
  int answers_owed;
  int answers_seen;
  int ranks_located;
  int weight_total_now;

  bit          sender_gaps = 1'b1;
  bit          receiver_stalls = 1'b1;
  int          hold_off_cycles = 0;
  int          cfg_writes = 0;
  int unsigned live_slots = kos_pkg::SIU_RESET;

  always #4 clk = ~clk;

  kth_occupied_slot_tree dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  kos_answer_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .answers_owed     (answers_owed),
    .answers_seen     (answers_seen),
    .ranks_located    (ranks_located),
    .weight_total_now (weight_total_now)
  );

  // result side: random stall bursts, plus one long hold-off on demand
  initial begin
    @(negedge clk);
    forever begin
      if (hold_off_cycles != 0) begin
        out_ready = 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  function automatic kos_pkg::in_item_t make_request(kos_pkg::action_t act, int slot,
                                                     int wgt, int rnk);
    kos_pkg::in_item_t r;
    r.action = act;
    r.slot   = kos_pkg::slot_t'(slot);
    r.weight = kos_pkg::weight_t'(wgt);
    r.rank   = kos_pkg::sum_t'(rnk);
    return r;
  endfunction

  // mostly sets and finds aimed at the live slots and the current total
  function automatic kos_pkg::in_item_t random_request(int unsigned live,
                                                       int unsigned total);
    kos_pkg::in_item_t r;
    int unsigned       pick;
    r.action = kos_pkg::ACT_FIND;
    r.slot   = kos_pkg::slot_t'($urandom);
    r.weight = kos_pkg::weight_t'($urandom);
    r.rank   = kos_pkg::sum_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      r.action = kos_pkg::ACT_REBUILD;
    end else if (pick < 5) begin
      r.action = ACT_NONE;
    end else if (pick < 52) begin
      r.action = kos_pkg::ACT_SET;
      if ($urandom_range(0, 9) != 0) begin
        r.slot = kos_pkg::slot_t'($urandom_range(0, live - 1));
      end
      case ($urandom_range(0, 7))
        0:       r.weight = '0;
        1:       r.weight = '1;
        default: begin
        end
      endcase
    end else begin
      case ($urandom_range(0, 9))
        0:       r.rank = '0;
        1:       r.rank = kos_pkg::sum_t'(total);
        2:       r.rank = kos_pkg::sum_t'(total + 1);
        3:       begin
        end
        default: r.rank = kos_pkg::sum_t'($urandom_range(0, total));
      endcase
    end
    return r;
  endfunction

  task automatic send_request(kos_pkg::in_item_t req);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (answers_owed != 0) @(negedge clk);
  endtask

  task automatic write_slot_count(kos_pkg::siu_t value);
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_writes++;
    if (value == '0) begin
      live_slots = 1;
    end else if (value > kos_pkg::SLOTS_DEF) begin
      live_slots = kos_pkg::SLOTS_DEF;
    end else begin
      live_slots = value;
    end
  endtask

  // stimulus and verdict
  initial begin
    int settings [7];
    settings = '{2047, 2, 1000, 37, 1025, 513, 1024};
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // default size: all weights one
    send_request(make_request(kos_pkg::ACT_FIND, 0, 0, 0));
    send_request(make_request(kos_pkg::ACT_FIND, 0, 0, 1));
    send_request(make_request(kos_pkg::ACT_FIND, 0, 0, 1024));
    send_request(make_request(kos_pkg::ACT_FIND, 0, 0, 1025));
    send_request(make_request(kos_pkg::ACT_FIND, 0, 0, 262143));
    send_request(make_request(kos_pkg::ACT_SET, 1023, 255, 0));
    send_request(make_request(kos_pkg::ACT_SET, 0, 0, 0));
    send_request(make_request(kos_pkg::ACT_FIND, 0, 0, 1));
    send_request(make_request(kos_pkg::ACT_FIND, 0, 0, 1277));
    send_request(make_request(ACT_NONE, 1023, 255, 262143));
    send_request(make_request(kos_pkg::ACT_REBUILD, 0, 0, 0));
    send_request(make_request(kos_pkg::ACT_FIND, 0, 0, 1024));

    // zero slot count clamps to a single slot
    wait_drained();
    write_slot_count('0);
    send_request(make_request(kos_pkg::ACT_SET, 1, 9, 0));
    send_request(make_request(kos_pkg::ACT_SET, 0, 255, 0));
    send_request(make_request(kos_pkg::ACT_FIND, 0, 0, 255));
    send_request(make_request(kos_pkg::ACT_FIND, 0, 0, 256));
    send_request(make_request(kos_pkg::ACT_SET, 1023, 255, 0));
    send_request(make_request(kos_pkg::ACT_FIND, 0, 0, 0));

    // random phases over several slot counts
    for (int p = 0; p < 7; p++) begin
      wait_drained();
      if (p == 6) begin
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
      end
      write_slot_count(kos_pkg::siu_t'(settings[p]));
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // long result stall while requests keep coming
        if (p == 2 && n == 40) begin
          hold_off_cycles = 400;
        end
        // sender stops until every answer is back
        if (p == 3 && n == 100) begin
          wait_drained();
        end
        send_request(random_request(live_slots, weight_total_now));
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    $display("checked %0d results, %0d ranks located, over %0d slot-count settings",
             answers_seen, ranks_located, cfg_writes + 1);
    $display("included one 400-cycle result stall with requests backed up");
    if (fail_count == 0 && answers_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/core/kos_pkg.sv
rtl/core/kos_dpath.sv
rtl/core/kos_ctrl.sv
rtl/core/kth_occupied_slot_tree.sv
rtl/core/kos_checker.sv
dv/kos_answer_checker.sv
dv/tb.sv
